// ----- sv/fir7g_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fir7g_pkg;

  // Filter dimensions.
  localparam int TAPS        = 7;
  localparam int SAMPLE_BITS = 12;
  localparam int COEF_BITS   = 16;
  localparam int NCOEF       = 7;
  localparam int MASTER_FRAC = 23;
  localparam int GAIN_BITS   = 12;
  localparam int GAIN_FRAC   = 8;
  localparam int DAC_BITS    = 12;
  localparam int SEL_BITS    = 2;

  // Derived widths of the datapath.
  localparam int TAP_IDX_W = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int ACC_W     = SAMPLE_BITS + 1 + COEF_BITS + $clog2(TAPS);
  localparam int MAG_W     = ACC_W - COEF_BITS;
  localparam int MUL_A_W   = (SAMPLE_BITS + 1 > MAG_W + 1) ? SAMPLE_BITS + 1 : MAG_W + 1;
  localparam int MUL_B_W   = (COEF_BITS > GAIN_BITS + 1) ? COEF_BITS : GAIN_BITS + 1;
  localparam int PROD_W    = MUL_A_W + MUL_B_W;
  localparam int SCALED_W  = MAG_W + GAIN_BITS - GAIN_FRAC;

  // Filter select codes; the unused code behaves as bypass.
  localparam logic [SEL_BITS-1:0] SEL_BYPASS    = 2'd0;
  localparam logic [SEL_BITS-1:0] SEL_HIGH_PASS = 2'd1;
  localparam logic [SEL_BITS-1:0] SEL_LOW_PASS  = 2'd2;

  localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(256);

  // Master coefficient sets in Q1.23.
  localparam int HP_MASTER [NCOEF] = '{
    -880804, -1214670, -1443679, 6863559, -1443679, -1214670, -880804
  };
  localparam int LP_MASTER [NCOEF] = '{
    672766, 721420, 752458, 762524, 752458, 721420, 672766
  };

  typedef logic signed [COEF_BITS-1:0] coef_t;
  typedef coef_t coef_arr_t [TAPS];

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] adc_sample;
    logic [SEL_BITS-1:0]    filter_select;
  } in_item_t;

  typedef struct packed {
    logic [DAC_BITS-1:0] dac_code;
    logic                overflow;
  } out_item_t;

  // Reduce a Q1.23 value to Q1.(COEF_BITS-1): round the magnitude, ties away from zero.
  function automatic coef_t coef_round(int m);
    int     sh;
    longint half;
    longint mag;
    sh   = MASTER_FRAC + 1 - COEF_BITS;
    half = (longint'(1) << sh) >> 1;
    mag  = (m < 0) ? -longint'(m) : longint'(m);
    mag  = (mag + half) >> sh;
    return COEF_BITS'((m < 0) ? -mag : mag);
  endfunction

  // Build a coefficient set for all taps; taps past the defined set are zero.
  function automatic coef_arr_t build_coefs(bit lowpass);
    coef_arr_t c;
    for (int i = 0; i < TAPS; i++) begin
      if (i < NCOEF) begin
        c[i] = lowpass ? coef_round(LP_MASTER[i]) : coef_round(HP_MASTER[i]);
      end else begin
        c[i] = '0;
      end
    end
    return c;
  endfunction

  localparam coef_arr_t HP_COEF = build_coefs(1'b0);
  localparam coef_arr_t LP_COEF = build_coefs(1'b1);

endpackage

`default_nettype wire

// ----- sv/dual_fir7_filter_with_gain.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | in_item: adc_sample, filter_select
// out     | output    | out_valid/out_ready| out_item: dac_code, overflow
// cfg     | input     | cfg_valid/cfg_ready| cfg_data: gain (Q4.8)
//
// A filtered item passes through the states MAC, ABS, MAG, GAIN, SCALE and OUT
// before the next acceptance; a bypass item goes straight to OUT. The single shared
// multiplier handles one tap per cycle and then the gain product.
// Reset (rst, synchronous) clears the history, sets gain to 1.0 and empties the
// output register. A result waits in the output register while out_ready is low;
// the next item is accepted meanwhile, and it waits for that register only at its end.
module dual_fir7_filter_with_gain (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire fir7g_pkg::in_item_t             in_item,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output fir7g_pkg::out_item_t                 out_item,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [fir7g_pkg::GAIN_BITS-1:0] cfg_data
);
  import fir7g_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_ABS,
    S_MAG,
    S_GAIN,
    S_SCALE,
    S_OUT
  } state_t;

  state_t                    state;
  logic [TAP_IDX_W-1:0]      tap_cnt;
  logic                      mac_pend;
  logic                      sel_lp;
  logic signed [ACC_W-1:0]   acc;
  logic [MAG_W-1:0]          mag;
  logic [GAIN_BITS-1:0]      gain;
  out_item_t                 res;

  logic                      in_fire;
  logic                      is_filter;
  logic [SAMPLE_BITS-1:0]    tap_data;
  coef_t                     coef;
  logic signed [MUL_A_W-1:0] op_a;
  logic signed [MUL_B_W-1:0] op_b;
  logic signed [PROD_W-1:0]  prod;
  logic [ACC_W-1:0]          abs_acc;
  logic [SCALED_W-1:0]       scaled;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign is_filter = (in_item.filter_select == SEL_HIGH_PASS) ||
                     (in_item.filter_select == SEL_LOW_PASS);

  fir7g_hist u_hist (
    .clk      (clk),
    .rst      (rst),
    .shift_en (in_fire && is_filter),
    .sample_in(in_item.adc_sample),
    .rd_idx   (tap_cnt),
    .rd_data  (tap_data)
  );

  // Operand selection for the shared multiplier: taps times coefficients, then gain.
  assign coef = sel_lp ? LP_COEF[tap_cnt] : HP_COEF[tap_cnt];

  always_comb begin
    if (state == S_GAIN) begin
      op_a = MUL_A_W'(mag);
      op_b = MUL_B_W'(gain);
    end else begin
      op_a = MUL_A_W'(tap_data);
      op_b = MUL_B_W'(coef);
    end
  end

  fir7g_mul u_mul (
    .clk (clk),
    .op_a(op_a),
    .op_b(op_b),
    .prod(prod)
  );

  // Magnitude of the sum and the scaled product.
  assign abs_acc = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
  assign scaled  = prod[GAIN_FRAC +: SCALED_W];

  // Gain register.
  always_ff @(posedge clk) begin
    if (rst) begin
      gain <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      gain <= cfg_data;
    end
  end

  // Sequencer, accumulator and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tap_cnt   <= '0;
      mac_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      mac_pend <= (state == S_MAC);
      if (mac_pend) begin
        acc <= acc + ACC_W'(prod);
      end
      // A taken result clears the register unless a new one is loaded in this cycle.
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            tap_cnt <= '0;
            acc     <= '0;
            sel_lp  <= (in_item.filter_select == SEL_LOW_PASS);
            if (is_filter) begin
              state <= S_MAC;
            end else begin
              res.dac_code <= DAC_BITS'(in_item.adc_sample);
              res.overflow <= 1'b0;
              state        <= S_OUT;
            end
          end
        end
        S_MAC: begin
          if (tap_cnt == TAP_IDX_W'(TAPS - 1)) begin
            state <= S_ABS;
          end else begin
            tap_cnt <= tap_cnt + 1'b1;
          end
        end
        S_ABS: begin
          // Last product is added in this cycle.
          state <= S_MAG;
        end
        S_MAG: begin
          mag   <= abs_acc[ACC_W-2 : COEF_BITS-1];
          state <= S_GAIN;
        end
        S_GAIN: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          res.dac_code <= scaled[DAC_BITS-1:0];
          res.overflow <= |scaled[SCALED_W-1:DAC_BITS];
          state        <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_item  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- sv/fir7g_hist.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fir7g_hist (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              shift_en,
  input  wire logic [fir7g_pkg::SAMPLE_BITS-1:0] sample_in,
  input  wire logic [fir7g_pkg::TAP_IDX_W-1:0]   rd_idx,
  output logic      [fir7g_pkg::SAMPLE_BITS-1:0] rd_data
);
  import fir7g_pkg::*;

  logic [SAMPLE_BITS-1:0] hist [TAPS];

  // Sample history, entry 0 the newest; cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        hist[i] <= '0;
      end
    end else if (shift_en) begin
      for (int i = TAPS - 1; i > 0; i--) begin
        hist[i] <= hist[i-1];
      end
      hist[0] <= sample_in;
    end
  end

  // Tap read for the multiply-accumulate sequence.
  assign rd_data = hist[rd_idx];

endmodule

`default_nettype wire

// ----- sv/fir7g_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fir7g_mul (
  input  wire logic                                clk,
  input  wire logic signed [fir7g_pkg::MUL_A_W-1:0] op_a,
  input  wire logic signed [fir7g_pkg::MUL_B_W-1:0] op_b,
  output logic signed      [fir7g_pkg::PROD_W-1:0]  prod
);
  import fir7g_pkg::*;

  // Shared signed multiplier with a registered product.
  always_ff @(posedge clk) begin
    prod <= PROD_W'(op_a * op_b);
  end

endmodule

`default_nettype wire

// ----- sv/fir7g_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fir7g_checker (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            in_valid,
  input wire logic                            in_ready,
  input wire fir7g_pkg::in_item_t             in_item,
  input wire logic                            out_valid,
  input wire logic                            out_ready,
  input wire fir7g_pkg::out_item_t            out_item
);
  import fir7g_pkg::*;

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an item is in progress");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // A new result appears only as the sequencer returns to idle.
  a_rise_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result appeared while busy");

  // A bypass item accepted while the output is empty comes out unchanged by way of the OUT state.
  a_bypass: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !out_valid &&
    (in_item.filter_select != SEL_HIGH_PASS) && (in_item.filter_select != SEL_LOW_PASS)
    |=> ##1 out_valid && !out_item.overflow &&
            (out_item.dac_code == DAC_BITS'($past(in_item.adc_sample, 2))))
    else $error("bypass item altered");

  // Reset empties the output.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dual_fir7_filter_with_gain fir7g_checker u_fir7g_checker (.*);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import fir7g_pkg::*;

  localparam int  WATCHDOG_CYCLES = 500000;
  localparam int  SETTLE_CYCLES   = 20;
  localparam int  PHASES          = 8;
  localparam int  ITEMS_PER_PHASE = 166;
  localparam int  MAX_SHOWN       = 30;
  localparam longint CODE_MAX     = (longint'(1) << DAC_BITS) - 1;
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  // The fourth select code has no filter and behaves as bypass.
  localparam logic [SEL_BITS-1:0] SEL_UNUSED = 2'd3;

  // Coefficient sets in Q1.15, newest tap first.
  localparam int HIGHPASS_Q15 [TAPS] = '{-3441, -4745, -5639, 26811, -5639, -4745, -3441};
  localparam int LOWPASS_Q15 [TAPS]  = '{2628, 2818, 2939, 2979, 2939, 2818, 2628};

  // Receiver back-pressure styles.
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_item_t              out_item;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [GAIN_BITS-1:0]   cfg_data  = '0;

  // Filter state mirrored by the predictor.
  logic [SAMPLE_BITS-1:0] hist_model [TAPS];
  logic [GAIN_BITS-1:0]   gain_model = GAIN_RESET;

  in_item_t               pending [$];
  out_item_t              dac_expected [$];

  bit                     in_fired    = 1'b0;
  int                     gap_left    = 0;
  int                     burst_left  = 0;
  rx_mode_t               stall_mode  = RX_OPEN;
  int                     stall_left  = 0;
  int                     stall_phase = 0;

  int                     error_count  = 0;
  int                     result_count = 0;
  int                     filtered_count = 0;
  int                     bypass_count = 0;
  int                     overflow_count = 0;
  int                     gain_writes = 0;

  dual_fir7_filter_with_gain i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  initial begin
    for (int i = 0; i < TAPS; i++) hist_model[i] = '0;
  end

  // Expected output for one accepted item; filtered items advance the history.
  function automatic out_item_t fir_predict(in_item_t it);
    out_item_t r;
    longint    acc;
    longint    mag;
    longint    scaled;
    acc = 0;
    if (it.filter_select != SEL_HIGH_PASS && it.filter_select != SEL_LOW_PASS) begin
      r.dac_code = it.adc_sample;
      r.overflow = 1'b0;
      return r;
    end
    for (int i = TAPS - 1; i > 0; i--) hist_model[i] = hist_model[i-1];
    hist_model[0] = it.adc_sample;
    for (int i = 0; i < TAPS; i++) begin
      if (it.filter_select == SEL_LOW_PASS) begin
        acc += longint'(LOWPASS_Q15[i]) * longint'(hist_model[i]);
      end else begin
        acc += longint'(HIGHPASS_Q15[i]) * longint'(hist_model[i]);
      end
    end
    mag        = ((acc < 0) ? -acc : acc) >> (COEF_BITS - 1);
    scaled     = (mag * longint'(gain_model)) >> GAIN_FRAC;
    r.dac_code = scaled[DAC_BITS-1:0];
    r.overflow = (scaled > CODE_MAX);
    return r;
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= MAX_SHOWN) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic queue_item(input logic [SAMPLE_BITS-1:0] s, input logic [SEL_BITS-1:0] f);
    in_item_t it;
    it.adc_sample    = s;
    it.filter_select = f;
    pending.push_back(it);
  endtask

  // Random samples; now and then a value is held long enough to fill the history.
  task automatic queue_random(input int count);
    logic [SAMPLE_BITS-1:0] s;
    logic [SEL_BITS-1:0]    f;
    int                     run;
    while (count > 0) begin
      case ($urandom_range(0, 9))
        0: f = SEL_BYPASS;
        1: f = SEL_UNUSED;
        2, 3, 4, 5: f = SEL_HIGH_PASS;
        default: f = SEL_LOW_PASS;
      endcase
      case ($urandom_range(0, 7))
        0: s = '0;
        1: s = SAMPLE_MAX;
        default: s = SAMPLE_BITS'($urandom_range(0, 4095));
      endcase
      run = ($urandom_range(0, 7) == 0) ? TAPS : 1;
      for (int k = 0; k < run && count > 0; k++) begin
        queue_item(s, f);
        count--;
      end
    end
  endtask

  // Gain writes happen only with the filter drained.
  task automatic write_gain(input logic [GAIN_BITS-1:0] g);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    gain_model = g;
    gain_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending.size() != 0 || in_valid || dac_expected.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Sender: bursts of items with random gaps in between.
  always @(negedge clk) begin : sender
    logic     next_valid;
    in_item_t next_item;
    next_valid = in_valid;
    next_item  = in_item;
    if (in_valid && in_fired) next_valid = 1'b0;
    if (!rst && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() > 0) begin
        next_item  = pending.pop_front();
        next_valid = 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        end
      end
    end
    in_valid <= next_valid;
    in_item  <= next_item;
  end

  // Receiver: switches between back-pressure styles at random intervals.
  always @(negedge clk) begin : receiver
    if (stall_left == 0) begin
      stall_mode = rx_mode_t'($urandom_range(0, 3));
      stall_left = $urandom_range(16, 96);
    end else begin
      stall_left--;
    end
    stall_phase++;
    case (stall_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
      default:   out_ready <= ((stall_phase % 5) < 2);
    endcase
  end

  // Monitor: predict on each accepted item, check each accepted result.
  always @(posedge clk) begin : monitor
    out_item_t want;
    in_fired = in_valid && in_ready && !rst;
    if (in_fired) begin
      dac_expected.push_back(fir_predict(in_item));
      if (in_item.filter_select == SEL_HIGH_PASS || in_item.filter_select == SEL_LOW_PASS) begin
        filtered_count++;
      end else begin
        bypass_count++;
      end
    end
    if (!rst && out_valid && out_ready) begin
      result_count++;
      if (dac_expected.size() == 0) begin
        flag_error("result arrived with nothing expected");
      end else begin
        want = dac_expected.pop_front();
        if (want.overflow) overflow_count++;
        if (out_item.dac_code !== want.dac_code) begin
          flag_error($sformatf("result %0d dac_code %0d, expected %0d",
                               result_count, out_item.dac_code, want.dac_code));
        end
        if (out_item.overflow !== want.overflow) begin
          flag_error($sformatf("result %0d overflow %0b, expected %0b",
                               result_count, out_item.overflow, want.overflow));
        end
      end
    end
  end

  // Watchdog.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycles, dac_expected.size());
    $display("tb: errors");
    $finish;
  end

  initial begin : stimulus
    logic [GAIN_BITS-1:0] g;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part at the reset gain: bypass extremes, the unused select,
    // a full low-pass history at the top code, then a high-pass impulse and a run at the top code.
    queue_item('0, SEL_BYPASS);
    queue_item(SAMPLE_MAX, SEL_BYPASS);
    queue_item(12'hAAA, SEL_UNUSED);
    queue_item(12'h555, SEL_UNUSED);
    for (int i = 0; i < TAPS; i++) queue_item(SAMPLE_MAX, SEL_LOW_PASS);
    queue_item(SAMPLE_MAX, SEL_BYPASS);
    for (int i = 0; i < TAPS; i++) queue_item((i == 3) ? SAMPLE_MAX : '0, SEL_HIGH_PASS);
    for (int i = 0; i < 3; i++) queue_item(SAMPLE_MAX, SEL_HIGH_PASS);
    wait_drained();

    // Random phases, each under its own gain; the sender holds off between them.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: g = '1;
        1: g = '0;
        2: g = 12'd1;
        3: g = GAIN_RESET;
        4: g = 12'd2048;
        default: g = GAIN_BITS'($urandom_range(0, 4095));
      endcase
      write_gain(g);
      queue_random(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("summary: %0d items (%0d filtered, %0d bypass), %0d results, %0d overflowed",
             filtered_count + bypass_count, filtered_count, bypass_count, result_count,
             overflow_count);
    $display("summary: %0d gain settings including zero and full scale, %0d mismatches",
             gain_writes, error_count);
    if (error_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
